// ===== src/dqp_pkg.sv =====
// Package for the DNS question parser: phase encoding, result kinds, result record.
// No dependencies; imported by dqp_core, dqp_out_stage and dns_question_parser.
package dqp_pkg;

    localparam int NAME_MAX_CHARS = 255;
    localparam int NAME_LEN_W     = $clog2(NAME_MAX_CHARS + 1);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_LLEN   = 3'd2,
        PH_LBYTES = 3'd3,
        PH_QTYPE  = 3'd4,
        PH_QCLASS = 3'd5
    } t_phase;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_NAME   = 3'd5;
    localparam logic [2:0] KIND_QTYPE  = 3'd6;
    localparam logic [2:0] KIND_QCLASS = 3'd7;

    localparam logic [3:0] IDX_ID_LOW    = 4'd1;
    localparam logic [3:0] IDX_FLAGS_LOW = 4'd3;
    localparam logic [3:0] IDX_LAST      = 4'd11;

    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_PRINT_MIN = 8'h20;
    localparam logic [7:0] CHAR_PRINT_MAX = 8'h7E;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic        is_response;
        logic [3:0]  op_code;
        logic        authoritative;
        logic        truncated;
        logic        recursion_desired;
        logic        recursion_available;
        logic [2:0]  reserved_bits;
        logic [3:0]  response_code;
        logic        last;
    } t_result;

endpackage

// ===== src/dns_question_parser.sv =====
// DNS header and question parser, top level.
// Depends on dqp_pkg, dqp_core and dqp_out_stage.
//
// Input channel: one payload byte per transaction (i_valid / o_ready), with
// i_start_of_message set on the first header byte; a set flag restarts the
// parse at any point. Output channel (o_valid / i_ready): one result per
// transaction - header ID and flags, the four counts, name characters, QTYPE,
// then QCLASS with o_last set. Bytes that complete nothing give no result.
// A result is registered into the result register, or into the skid entry during a
// stall. Throughput: one byte per cycle while o_ready is high, set by the single decode stage
// between the parser state and the result register.
// Reset: the parser goes idle and ignores bytes until a start flag; the
// result register and skid entry are emptied.
// Stall: while i_ready is low one more result is held in a skid entry; once it
// is occupied o_ready drops until the result register drains.
module dns_question_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [15:0] o_value,
    output logic        o_is_response,
    output logic [3:0]  o_op_code,
    output logic        o_authoritative,
    output logic        o_truncated,
    output logic        o_recursion_desired,
    output logic        o_recursion_available,
    output logic [2:0]  o_reserved_bits,
    output logic [3:0]  o_response_code,
    output logic        o_last
);
    import dqp_pkg::*;

    logic    accept;
    logic    res_valid;
    logic    can_accept;
    t_result res;
    t_result out_res;

    assign o_ready = can_accept;
    assign accept  = i_valid && can_accept;

    dqp_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_data_byte        (i_data_byte),
        .i_start_of_message (i_start_of_message),
        .o_res_valid        (res_valid),
        .o_res              (res)
    );

    dqp_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept && res_valid),
        .i_res        (res),
        .o_can_accept (can_accept),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_res        (out_res)
    );

    assign o_kind                = out_res.kind;
    assign o_value               = out_res.value;
    assign o_is_response         = out_res.is_response;
    assign o_op_code             = out_res.op_code;
    assign o_authoritative       = out_res.authoritative;
    assign o_truncated           = out_res.truncated;
    assign o_recursion_desired   = out_res.recursion_desired;
    assign o_recursion_available = out_res.recursion_available;
    assign o_reserved_bits       = out_res.reserved_bits;
    assign o_response_code       = out_res.response_code;
    assign o_last                = out_res.last;

endmodule

// ===== src/dqp_core.sv =====
// Parser state and per-byte decode: updates the walk state on each accepted byte
// and forms at most one result. Depends on dqp_pkg.
module dqp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_start_of_message,
    output logic             o_res_valid,
    output dqp_pkg::t_result o_res
);
    import dqp_pkg::*;

    t_phase                r_phase, n_phase;
    logic [3:0]            r_idx, n_idx;
    logic [7:0]            r_high, n_high;
    logic [15:0]           r_msg_id, n_msg_id;
    logic [7:0]            r_label_rem, n_label_rem;
    logic [NAME_LEN_W-1:0] r_name_len, n_name_len;
    logic                  r_first_label, n_first_label;

    t_phase      cur_phase;
    logic [3:0]  cur_idx;
    logic [15:0] word;
    logic [7:0]  label_dec;
    logic        name_full;
    logic        printable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_idx         <= '0;
            r_high        <= '0;
            r_msg_id      <= '0;
            r_label_rem   <= '0;
            r_name_len    <= '0;
            r_first_label <= 1'b1;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_idx         <= n_idx;
            r_high        <= n_high;
            r_msg_id      <= n_msg_id;
            r_label_rem   <= n_label_rem;
            r_name_len    <= n_name_len;
            r_first_label <= n_first_label;
        end
    end

    always_comb begin
        cur_phase     = i_start_of_message ? PH_HEADER : r_phase;
        cur_idx       = i_start_of_message ? 4'd0 : r_idx;
        word          = {r_high, i_data_byte};
        label_dec     = r_label_rem - 8'd1;
        name_full     = (r_name_len >= NAME_LEN_W'(NAME_MAX_CHARS));
        printable     = (i_data_byte >= CHAR_PRINT_MIN) && (i_data_byte <= CHAR_PRINT_MAX);

        n_phase       = cur_phase;
        n_idx         = cur_idx;
        n_high        = r_high;
        n_msg_id      = r_msg_id;
        n_label_rem   = r_label_rem;
        n_name_len    = r_name_len;
        n_first_label = r_first_label;
        o_res_valid   = 1'b0;
        o_res         = '0;

        case (cur_phase)
            PH_HEADER: begin
                if (!cur_idx[0]) begin
                    n_high = i_data_byte;
                    n_idx  = cur_idx + 4'd1;
                end else if (cur_idx == IDX_ID_LOW) begin
                    n_msg_id = word;
                    n_idx    = cur_idx + 4'd1;
                end else begin
                    o_res_valid = 1'b1;
                    if (cur_idx == IDX_FLAGS_LOW) begin
                        o_res.kind                = KIND_HEADER;
                        o_res.value               = r_msg_id;
                        o_res.is_response         = word[15];
                        o_res.op_code             = word[14:11];
                        o_res.authoritative       = word[10];
                        o_res.truncated           = word[9];
                        o_res.recursion_desired   = word[8];
                        o_res.recursion_available = word[7];
                        o_res.reserved_bits       = word[6:4];
                        o_res.response_code       = word[3:0];
                    end else begin
                        o_res.kind  = cur_idx[3:1] - 3'd1;
                        o_res.value = word;
                    end
                    if (cur_idx >= IDX_LAST) begin
                        n_phase       = PH_LLEN;
                        n_idx         = '0;
                        n_first_label = 1'b1;
                        n_name_len    = '0;
                        n_label_rem   = '0;
                    end else begin
                        n_idx = cur_idx + 4'd1;
                    end
                end
            end
            PH_LLEN: begin
                if (i_data_byte == 8'd0) begin
                    n_phase = PH_QTYPE;
                    n_idx   = '0;
                end else begin
                    n_label_rem = i_data_byte;
                    n_phase     = PH_LBYTES;
                    if (r_first_label) begin
                        n_first_label = 1'b0;
                    end else if (!name_full) begin
                        n_name_len  = r_name_len + NAME_LEN_W'(1);
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_NAME;
                        o_res.value = {8'd0, CHAR_DOT};
                    end
                end
            end
            PH_LBYTES: begin
                n_label_rem = label_dec;
                if (label_dec == 8'd0) begin
                    n_phase = PH_LLEN;
                end
                if (!name_full) begin
                    n_name_len  = r_name_len + NAME_LEN_W'(1);
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_NAME;
                    o_res.value = {8'd0, printable ? i_data_byte : CHAR_DOT};
                end
            end
            PH_QTYPE, PH_QCLASS: begin
                if (cur_idx == 4'd0) begin
                    n_high = i_data_byte;
                    n_idx  = 4'd1;
                end else begin
                    n_idx       = '0;
                    o_res_valid = 1'b1;
                    o_res.value = word;
                    if (cur_phase == PH_QTYPE) begin
                        o_res.kind = KIND_QTYPE;
                        n_phase    = PH_QCLASS;
                    end else begin
                        o_res.kind = KIND_QCLASS;
                        o_res.last = 1'b1;
                        n_phase    = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = cur_phase;
            end
        endcase
    end

endmodule

// ===== src/dqp_out_stage.sv =====
// Result register with a skid entry so the byte side keeps flowing during a stall.
// Depends on dqp_pkg.
module dqp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dqp_pkg::t_result i_res,
    output logic             o_can_accept,
    output logic             o_valid,
    input  logic             i_ready,
    output dqp_pkg::t_result o_res
);
    import dqp_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free     = !r_out_valid || i_ready;
    assign o_can_accept = !r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_res        = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || i_push;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for dns_question_parser: directed byte table, then random DNS messages
// checked against a cycle-free parser model. Depends on dqp_pkg and the RTL only.
module tb_top;
    import dqp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int SHOW_MAX     = 10;

    localparam logic [2:0] KIND_QDCOUNT = 3'd1;
    localparam logic [2:0] KIND_ANCOUNT = 3'd2;
    localparam logic [2:0] KIND_ARCOUNT = 3'd4;

    localparam t_result HDR_ALL_ONES = t_result'({KIND_HEADER, 16'hFFFF, 1'b1, 4'hF,
                                                  4'hF, 3'h7, 4'hF, 1'b0});
    localparam t_result HDR_ALL_ZERO = t_result'({KIND_HEADER, 16'h0000, 17'h0});
    localparam t_result QD_ONE       = t_result'({KIND_QDCOUNT, 16'h0001, 17'h0});
    localparam t_result AN_ALL_ONES  = t_result'({KIND_ANCOUNT, 16'hFFFF, 17'h0});
    localparam t_result AR_ZERO      = t_result'({KIND_ARCOUNT, 16'h0000, 17'h0});
    localparam t_result CH_DOT       = t_result'({KIND_NAME, 8'h00, CHAR_DOT, 17'h0});
    localparam t_result CH_TILDE     = t_result'({KIND_NAME, 16'h007E, 17'h0});
    localparam t_result QCLASS_ONES  = t_result'({KIND_QCLASS, 16'hFFFF, 16'h0, 1'b1});
    localparam t_result NO_PIN       = t_result'(36'h0);

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        logic       pinned;
        t_result    res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_start_of_message;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [15:0] o_value;
    logic        o_is_response;
    logic [3:0]  o_op_code;
    logic        o_authoritative;
    logic        o_truncated;
    logic        o_recursion_desired;
    logic        o_recursion_available;
    logic [2:0]  o_reserved_bits;
    logic [3:0]  o_response_code;
    logic        o_last;

    logic        pin_on;
    t_result     pin_res;

    t_result     dns_expect_q[$];
    t_stim_row   dir_rows[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    t_phase      pr_phase;
    logic [3:0]  pr_idx;
    logic [7:0]  pr_hold;
    logic [15:0] pr_id;
    logic [7:0]  pr_left;
    int          pr_name_len;
    logic        pr_first;

    dns_question_parser i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_data_byte           (i_data_byte),
        .i_start_of_message    (i_start_of_message),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_kind                (o_kind),
        .o_value               (o_value),
        .o_is_response         (o_is_response),
        .o_op_code             (o_op_code),
        .o_authoritative       (o_authoritative),
        .o_truncated           (o_truncated),
        .o_recursion_desired   (o_recursion_desired),
        .o_recursion_available (o_recursion_available),
        .o_reserved_bits       (o_reserved_bits),
        .o_response_code       (o_response_code),
        .o_last                (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dns_question_parser test failed");
            $finish;
        end
    end

    function automatic bit emit_name_char(input logic [7:0] ch, output t_result res);
        res = '0;
        emit_name_char = 1'b0;
        if (pr_name_len < NAME_MAX_CHARS) begin
            pr_name_len++;
            res.kind = KIND_NAME;
            res.value = {8'h00, ch};
            emit_name_char = 1'b1;
        end
    endfunction

    function automatic bit decode_dns_byte(input logic [7:0] b, input logic sof,
                                           output t_result res);
        logic [15:0] word;
        logic [3:0]  count_sel;
        logic [7:0]  ch;
        res = '0;
        decode_dns_byte = 1'b0;
        if (sof) begin
            pr_phase = PH_HEADER;
            pr_idx = '0;
        end
        case (pr_phase)
            PH_HEADER: begin
                if (!pr_idx[0]) begin
                    pr_hold = b;
                    pr_idx = pr_idx + 4'd1;
                end else begin
                    word = {pr_hold, b};
                    if (pr_idx == IDX_ID_LOW) begin
                        pr_id = word;
                        pr_idx = pr_idx + 4'd1;
                    end else begin
                        decode_dns_byte = 1'b1;
                        if (pr_idx == IDX_FLAGS_LOW) begin
                            res.kind = KIND_HEADER;
                            res.value = pr_id;
                            res.is_response = word[15];
                            res.op_code = word[14:11];
                            res.authoritative = word[10];
                            res.truncated = word[9];
                            res.recursion_desired = word[8];
                            res.recursion_available = word[7];
                            res.reserved_bits = word[6:4];
                            res.response_code = word[3:0];
                        end else begin
                            count_sel = (pr_idx - IDX_FLAGS_LOW) >> 1;
                            res.kind = count_sel[2:0];
                            res.value = word;
                        end
                        if (pr_idx >= IDX_LAST) begin
                            pr_phase = PH_LLEN;
                            pr_idx = '0;
                            pr_first = 1'b1;
                            pr_name_len = 0;
                            pr_left = '0;
                        end else begin
                            pr_idx = pr_idx + 4'd1;
                        end
                    end
                end
            end
            PH_LLEN: begin
                if (b == 8'h00) begin
                    pr_phase = PH_QTYPE;
                    pr_idx = '0;
                end else begin
                    pr_left = b;
                    pr_phase = PH_LBYTES;
                    if (pr_first) pr_first = 1'b0;
                    else decode_dns_byte = emit_name_char(CHAR_DOT, res);
                end
            end
            PH_LBYTES: begin
                pr_left = pr_left - 8'd1;
                if (pr_left == 8'h00) pr_phase = PH_LLEN;
                ch = (b >= CHAR_PRINT_MIN && b <= CHAR_PRINT_MAX) ? b : CHAR_DOT;
                decode_dns_byte = emit_name_char(ch, res);
            end
            PH_QTYPE, PH_QCLASS: begin
                if (pr_idx == 4'h0) begin
                    pr_hold = b;
                    pr_idx = 4'h1;
                end else begin
                    pr_idx = '0;
                    decode_dns_byte = 1'b1;
                    res.value = {pr_hold, b};
                    if (pr_phase == PH_QTYPE) begin
                        res.kind = KIND_QTYPE;
                        pr_phase = PH_QCLASS;
                    end else begin
                        res.kind = KIND_QCLASS;
                        res.last = 1'b1;
                        pr_phase = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_result guess;
        t_result want;
        t_result got;
        bit      has;
        if (!i_rst_n) begin
            pr_phase = PH_IDLE;
            pr_idx = '0;
            pr_hold = '0;
            pr_id = '0;
            pr_left = '0;
            pr_name_len = 0;
            pr_first = 1'b1;
        end else begin
            if (i_valid && o_ready) begin
                has = decode_dns_byte(i_data_byte, i_start_of_message, guess);
                if (pin_on) dns_expect_q.push_back(pin_res);
                else if (has) dns_expect_q.push_back(guess);
            end
            if (o_valid && i_ready) begin
                got = t_result'({o_kind, o_value, o_is_response, o_op_code, o_authoritative,
                                 o_truncated, o_recursion_desired, o_recursion_available,
                                 o_reserved_bits, o_response_code, o_last});
                if (dns_expect_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_MAX)
                        $display("unexpected result: kind %0d value %h flags %h last %b",
                                 got.kind, got.value, got[16:1], got.last);
                end else begin
                    want = dns_expect_q.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOW_MAX)
                            $display({"mismatch: kind %0d/%0d value %h/%h flags %h/%h ",
                                      "last %b/%b (expected/actual)"},
                                     want.kind, got.kind, want.value, got.value,
                                     want[16:1], got[16:1], want.last, got.last);
                    end
                end
            end
        end
    end

    task automatic add_row(input logic [7:0] data, input logic sof, input logic pinned,
                           input t_result res);
        dir_rows.push_back({data, sof, pinned, res});
    endtask

    task automatic send_byte(input logic [7:0] data, input logic sof, input logic pinned,
                             input t_result res);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= data;
        i_start_of_message <= sof;
        pin_on <= pinned;
        pin_res <= res;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (dns_expect_q.size() != 0);
    endtask

    task automatic send_message(input bit broken);
        logic [7:0] msg[$];
        int         nlabels;
        int         len;
        int         cut;
        int         k;
        int         j;
        bit         long_name;
        for (k = 0; k < 12; k++) msg.push_back(8'($urandom_range(255)));
        long_name = ($urandom_range(24) == 0);
        nlabels = long_name ? $urandom_range(4, 6) : $urandom_range(0, 4);
        for (k = 0; k < nlabels; k++) begin
            if (long_name)
                len = ($urandom_range(3) == 0) ? $urandom_range(192, 255)
                                               : $urandom_range(40, 63);
            else
                len = ($urandom_range(7) == 0) ? $urandom_range(11, 63)
                                               : $urandom_range(1, 10);
            msg.push_back(8'(len));
            for (j = 0; j < len; j++)
                msg.push_back(($urandom_range(3) != 0) ? 8'($urandom_range(32, 126))
                                                       : 8'($urandom_range(255)));
        end
        msg.push_back(8'h00);
        for (k = 0; k < 4; k++) msg.push_back(8'($urandom_range(255)));
        cut = broken ? $urandom_range(1, msg.size() - 1) : msg.size();
        for (k = 0; k < cut; k++) begin
            send_byte(msg[k], (k == 0), 1'b0, NO_PIN);
            bytes_sent++;
        end
    endtask

    initial begin : stimulus
        int phase_no;
        int k;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_start_of_message = 1'b0;
        pin_on = 1'b0;
        pin_res = NO_PIN;

        // idle byte, all-ones header, restart into all-zero header
        add_row(8'hAA, 1'b0, 1'b0, NO_PIN);
        add_row(8'hFF, 1'b1, 1'b0, NO_PIN);
        add_row(8'hFF, 1'b0, 1'b0, NO_PIN);
        add_row(8'hFF, 1'b0, 1'b0, NO_PIN);
        add_row(8'hFF, 1'b0, 1'b1, HDR_ALL_ONES);
        add_row(8'h00, 1'b1, 1'b0, NO_PIN);
        add_row(8'h00, 1'b0, 1'b0, NO_PIN);
        add_row(8'h00, 1'b0, 1'b0, NO_PIN);
        add_row(8'h00, 1'b0, 1'b1, HDR_ALL_ZERO);
        add_row(8'h00, 1'b0, 1'b0, NO_PIN);
        add_row(8'h01, 1'b0, 1'b1, QD_ONE);
        add_row(8'hFF, 1'b0, 1'b0, NO_PIN);
        add_row(8'hFF, 1'b0, 1'b1, AN_ALL_ONES);
        add_row(8'h12, 1'b0, 1'b0, NO_PIN);
        add_row(8'h34, 1'b0, 1'b0, NO_PIN);
        add_row(8'h00, 1'b0, 1'b0, NO_PIN);
        add_row(8'h00, 1'b0, 1'b1, AR_ZERO);
        // name: two labels, unprintable and edge printable bytes
        add_row(8'h02, 1'b0, 1'b0, NO_PIN);
        add_row(8'h1F, 1'b0, 1'b1, CH_DOT);
        add_row(8'h7E, 1'b0, 1'b1, CH_TILDE);
        add_row(8'h01, 1'b0, 1'b0, NO_PIN);
        add_row(8'h20, 1'b0, 1'b0, NO_PIN);
        add_row(8'h00, 1'b0, 1'b0, NO_PIN);
        add_row(8'h00, 1'b0, 1'b0, NO_PIN);
        add_row(8'h01, 1'b0, 1'b0, NO_PIN);
        add_row(8'hFF, 1'b0, 1'b0, NO_PIN);
        add_row(8'hFF, 1'b0, 1'b1, QCLASS_ONES);
        // trailing byte after the question goes unparsed
        add_row(8'h55, 1'b0, 1'b0, NO_PIN);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_byte(dir_rows[k].data, dir_rows[k].sof, dir_rows[k].pinned,
                      dir_rows[k].res);
        drain_results();

        for (phase_no = 0; phase_no < 4; phase_no++) begin
            case (phase_no)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            while (bytes_sent < (phase_no + 1) * RANDOM_ITEMS / 4) begin
                send_message($urandom_range(7) == 0);
                if ($urandom_range(7) == 0) begin
                    // noise between messages, now and then with a stray start flag
                    for (k = $urandom_range(1, 3); k > 0; k--)
                        send_byte(8'($urandom_range(255)), ($urandom_range(3) == 0),
                                  1'b0, NO_PIN);
                end
            end
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        if (dns_expect_q.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("dns_question_parser test passed");
        end else begin
            $display("dns_question_parser test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/dqp_pkg.sv
src/dqp_core.sv
src/dqp_out_stage.sv
src/dns_question_parser.sv
tb/sv/tb_top.sv
